// File: rtl/dhb_pkg.sv
// shared types and constants of the dual h-bridge drive
// command codes, motion state codes, register indexes and reset values
// no dependencies
package dhb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 9;
    localparam int DUR_W      = 16;
    localparam int PWM_W      = 8;

    localparam logic [15:0]      PWM_FULL_SCALE = 16'd255;
    localparam logic [PWM_W-1:0] MAX_SPEED_RST  = 8'd255;
    localparam logic [PWM_W-1:0] MIN_SPEED_RST  = 8'd0;
    localparam logic [DUR_W-1:0] RAMP_DUR_RST   = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_MIN_SPEED = 2'd1,
        CFG_RAMP_DUR  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_FWD       = 4'd0,
        OP_BACK      = 4'd1,
        OP_TURN_L    = 4'd2,
        OP_TURN_R    = 4'd3,
        OP_CURVE_L   = 4'd4,
        OP_CURVE_R   = 4'd5,
        OP_SET_L     = 4'd6,
        OP_SET_R     = 4'd7,
        OP_STOP      = 4'd8,
        OP_ESTOP     = 4'd9,
        OP_SOFT      = 4'd10,
        OP_TICK      = 4'd11,
        OP_CAL_START = 4'd12,
        OP_CAL_END   = 4'd13,
        OP_RESET     = 4'd14
    } t_op;

    typedef enum logic [2:0] {
        MODE_STOP    = 3'd0,
        MODE_FWD     = 3'd1,
        MODE_BACK    = 3'd2,
        MODE_TURN_L  = 3'd3,
        MODE_TURN_R  = 3'd4,
        MODE_CURVE_L = 3'd5,
        MODE_CURVE_R = 3'd6,
        MODE_CAL     = 3'd7
    } t_mode;

    // motion state that a motion command selects
    function automatic t_mode mode_of(input logic [3:0] op);
        t_mode m;
        case (op)
            OP_FWD:     m = MODE_FWD;
            OP_BACK:    m = MODE_BACK;
            OP_TURN_L:  m = MODE_TURN_L;
            OP_TURN_R:  m = MODE_TURN_R;
            OP_CURVE_L: m = MODE_CURVE_L;
            OP_CURVE_R: m = MODE_CURVE_R;
            default:    m = MODE_STOP;
        endcase
        return m;
    endfunction

    // magnitude of a signed level
    function automatic logic [SPEED_W-1:0] mag9(input logic signed [SPEED_W-1:0] s);
        logic [SPEED_W-1:0] m;
        m = s[SPEED_W-1] ? SPEED_W'(-s) : SPEED_W'(s);
        return m;
    endfunction

endpackage

// File: rtl/dual_h_bridge_drive_with_soft_stop.sv
// top level of the dual h-bridge drive with soft stop
// command decode, side levels, soft stop ramp with shared serial divider
// depends on dhb_pkg
//
// Each command transaction on the input stream gives exactly one result
// transaction with the bridge pin levels of both sides and the status. Every
// command except a ramp tick that scales the levels loads the result register
// at the accepting edge. A ramp tick that scales the levels is accepted, then
// each side passes through the 8x16 multiplier state and then the shared
// restoring divide step, which produces one quotient bit per cycle. The input is
// ready while no ramp tick is in work and the result register is empty or being
// read out, so the next command is taken no earlier than the edge at which a
// waiting result is read out.
// Configuration is written with i_cfg_we, i_cfg_idx and i_cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce; writes to an unused index are ignored.
module dual_h_bridge_drive_with_soft_stop
    import dhb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] left_speed, [17:9] right_speed, [23:18] zero
    input  logic [23:0]           s_axis_tdata,
    // [3:0] operation
    input  logic [3:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] left_in1, [1] left_in2, [9:2] left_pwm, [10] right_in1, [11] right_in2,
    // [19:12] right_pwm, [22:20] motion_state, [23] rejected, [24] calibrated,
    // [25] ramp_active, [31:26] zero
    output logic [31:0]           m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state r_state, n_state;

    logic [PWM_W-1:0] r_max, n_max;
    logic [PWM_W-1:0] r_min, n_min;
    logic [DUR_W-1:0] r_dur, n_dur;

    logic signed [SPEED_W-1:0] r_left, n_left;
    logic signed [SPEED_W-1:0] r_right, n_right;
    t_mode                     r_mode, n_mode;
    logic                      r_cal, n_cal;
    logic                      r_ramp_on, n_ramp_on;
    logic [DUR_W-1:0]          r_elapsed, n_elapsed;
    logic signed [SPEED_W-1:0] r_start_l, n_start_l;
    logic signed [SPEED_W-1:0] r_start_r, n_start_r;

    // divider datapath
    logic             r_side, n_side;
    logic [2:0]       r_cnt, n_cnt;
    logic [DUR_W-1:0] r_rem, n_rem;
    logic [7:0]       r_low, n_low;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;

    logic                      accept;
    logic [3:0]                op;
    logic signed [SPEED_W-1:0] ls, rs;
    logic [SPEED_W-1:0]        ls_mag, rs_mag;
    logic                      ls_ok, rs_ok;
    logic                      finish;
    logic                      rej;
    logic [DUR_W-1:0]          e_inc;
    logic signed [SPEED_W-1:0] start_sel;
    logic [SPEED_W-1:0]        start_mag;
    logic [23:0]               prod;
    logic [DUR_W:0]            shifted;
    logic [DUR_W:0]            diff;
    logic                      ge;
    logic [7:0]                quot;
    logic signed [SPEED_W-1:0] scaled;
    logic [SPEED_W-1:0]        l_mag, r_mag;

    function automatic logic spd_ok(input logic signed [SPEED_W-1:0] s,
                                    input logic [PWM_W-1:0] lo,
                                    input logic [PWM_W-1:0] hi);
        logic ok;
        ok = (s >= $signed({1'b0, lo})) && (s <= $signed({1'b0, hi}));
        return ok;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign op     = s_axis_tuser;
    assign ls     = $signed(s_axis_tdata[8:0]);
    assign rs     = $signed(s_axis_tdata[17:9]);
    assign ls_mag = mag9(ls);
    assign rs_mag = mag9(rs);
    assign ls_ok  = spd_ok(ls, r_min, r_max);
    assign rs_ok  = spd_ok(rs, r_min, r_max);

    always_comb begin
        n_state     = r_state;
        n_max       = r_max;
        n_min       = r_min;
        n_dur       = r_dur;
        n_left      = r_left;
        n_right     = r_right;
        n_mode      = r_mode;
        n_cal       = r_cal;
        n_ramp_on   = r_ramp_on;
        n_elapsed   = r_elapsed;
        n_start_l   = r_start_l;
        n_start_r   = r_start_r;
        n_side      = r_side;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_low       = r_low;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        finish      = 1'b0;
        rej         = 1'b0;
        e_inc       = (r_elapsed != {DUR_W{1'b1}}) ? r_elapsed + 1'b1 : r_elapsed;

        start_sel = r_side ? r_start_r : r_start_l;
        start_mag = mag9(start_sel);
        prod      = start_mag[7:0] * (r_dur - r_elapsed);
        shifted   = {r_rem, r_low[7]};
        ge        = shifted >= {1'b0, r_dur};
        diff      = shifted - {1'b0, r_dur};
        quot      = {r_low[6:0], ge};
        scaled    = start_sel[SPEED_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_SPEED: begin
                    n_max = ({8'd0, i_cfg_data[7:0]} > PWM_FULL_SCALE) ?
                            PWM_FULL_SCALE[7:0] : i_cfg_data[7:0];
                end
                CFG_MIN_SPEED: begin
                    n_min = (i_cfg_data[7:0] > r_max) ? r_max : i_cfg_data[7:0];
                end
                CFG_RAMP_DUR: n_dur = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    finish = 1'b1;
                    unique case (op) inside
                        OP_FWD, OP_BACK, OP_TURN_L, OP_TURN_R: begin
                            if (!ls_ok) begin
                                rej = 1'b1;
                            end else begin
                                n_left  = (op == OP_BACK || op == OP_TURN_L) ? -ls : ls;
                                n_right = (op == OP_BACK || op == OP_TURN_R) ? -ls : ls;
                                n_mode  = mode_of(op);
                            end
                        end
                        OP_CURVE_L, OP_CURVE_R: begin
                            if (!ls_ok || !rs_ok) begin
                                rej = 1'b1;
                            end else begin
                                n_left  = ls;
                                n_right = rs;
                                n_mode  = mode_of(op);
                            end
                        end
                        OP_SET_L: begin
                            if (ls_mag < {1'b0, r_min} || ls_mag > {1'b0, r_max}) begin
                                rej = 1'b1;
                            end else begin
                                n_left = ls;
                            end
                        end
                        OP_SET_R: begin
                            if (rs_mag < {1'b0, r_min} || rs_mag > {1'b0, r_max}) begin
                                rej = 1'b1;
                            end else begin
                                n_right = rs;
                            end
                        end
                        OP_STOP, OP_ESTOP, OP_RESET: begin
                            n_left    = '0;
                            n_right   = '0;
                            n_mode    = MODE_STOP;
                            n_ramp_on = 1'b0;
                            if (op == OP_RESET) begin
                                n_cal = 1'b0;
                            end
                        end
                        OP_SOFT: begin
                            n_ramp_on = 1'b1;
                            n_elapsed = '0;
                            n_start_l = r_left;
                            n_start_r = r_right;
                        end
                        OP_TICK: begin
                            if (r_ramp_on) begin
                                n_elapsed = e_inc;
                                if (e_inc >= r_dur) begin
                                    n_left    = '0;
                                    n_right   = '0;
                                    n_mode    = MODE_STOP;
                                    n_ramp_on = 1'b0;
                                end else begin
                                    // scale both sides before the result goes out
                                    finish  = 1'b0;
                                    n_side  = 1'b0;
                                    n_state = S_MUL;
                                end
                            end
                        end
                        OP_CAL_START: begin
                            n_mode = MODE_CAL;
                            n_cal  = 1'b0;
                        end
                        OP_CAL_END: begin
                            if (r_mode == MODE_CAL) begin
                                n_left    = '0;
                                n_right   = '0;
                                n_mode    = MODE_STOP;
                                n_ramp_on = 1'b0;
                                n_cal     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                // numerator below 256*duration, so the upper part starts below the divisor
                n_rem   = prod[23:8];
                n_low   = prod[7:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
                n_low = quot;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd7) begin
                    if (r_side) begin
                        n_right = scaled;
                        finish  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_left  = scaled;
                        n_side  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        l_mag = mag9(n_left);
        r_mag = mag9(n_right);
        if (finish) begin
            n_out_valid = 1'b1;
            n_out_data  = {6'd0, n_ramp_on, n_cal, rej, n_mode,
                           r_mag[7:0], n_right[SPEED_W-1],
                           (!n_right[SPEED_W-1] && n_right != '0),
                           l_mag[7:0], n_left[SPEED_W-1],
                           (!n_left[SPEED_W-1] && n_left != '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= MAX_SPEED_RST;
            r_min       <= MIN_SPEED_RST;
            r_dur       <= RAMP_DUR_RST;
            r_left      <= '0;
            r_right     <= '0;
            r_mode      <= MODE_STOP;
            r_cal       <= 1'b0;
            r_ramp_on   <= 1'b0;
            r_elapsed   <= '0;
            r_start_l   <= '0;
            r_start_r   <= '0;
            r_side      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_min       <= n_min;
            r_dur       <= n_dur;
            r_left      <= n_left;
            r_right     <= n_right;
            r_mode      <= n_mode;
            r_cal       <= n_cal;
            r_ramp_on   <= n_ramp_on;
            r_elapsed   <= n_elapsed;
            r_start_l   <= n_start_l;
            r_start_r   <= n_start_r;
            r_side      <= n_side;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_rem      <= n_rem;
        r_low      <= n_low;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // divide step keeps the partial remainder below the divisor
    a_rem_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dur))
        else $error("partial remainder not below ramp duration");

    // scaling only happens for a running ramp
    a_busy_ramping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_ramp_on)
        else $error("divider busy without a running ramp");

    // the result slot is empty while a ramp tick is in work
    a_busy_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while divider busy");

    // min clamp on write holds against the current max
    a_min_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_MIN_SPEED) |=> (r_min <= r_max))
        else $error("min speed above max speed after write");
`endif

endmodule
